// ----- sv/pdos_pkg.sv -----
// ----------------------------------------------------------------------------
// pdos_pkg
// Shared constants and types for the periodic disk overlap store.
// ----------------------------------------------------------------------------
package pdos_pkg;

  localparam int unsigned MAX_POINTS = 2048;
  localparam int unsigned ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned OUT_CNT_W  = 12;
  localparam int unsigned CMP_W      = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

  localparam int unsigned COORD_W    = 18;
  localparam int unsigned D2_W       = 34;
  localparam int unsigned DIFF_W     = COORD_W + 2;   // difference plus box shift
  localparam int unsigned MAG_W      = DIFF_W - 1;
  localparam int unsigned SQ_W       = 2 * MAG_W;

  localparam logic [D2_W-1:0] D2_RESET = D2_W'(42949673);
  localparam logic signed [DIFF_W-1:0] BOX_ONE = DIFF_W'(65536);

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned PADDR_W = 4;
  localparam logic REG_D2 = 1'b0;   // register index, taken from paddr[3]

  typedef enum logic [1:0] {
    MODE_TEST   = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } pdos_mode_e;

  typedef struct packed {
    logic valid;
    logic hit;
  } pdos_hit_t;

endpackage

// ----- sv/pdos_in_if.sv -----
// ----------------------------------------------------------------------------
// pdos_in_if
// Item channel into the disk store: mode, trial centre and remove count.
// ----------------------------------------------------------------------------
interface pdos_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic signed [pdos_pkg::COORD_W-1:0] trial_x;
  logic signed [pdos_pkg::COORD_W-1:0] trial_y;
  logic [11:0]                         remove_count;

  modport source (output valid, output mode, output trial_x, output trial_y,
                  output remove_count, input ready);
  modport sink   (input valid, input mode, input trial_x, input trial_y,
                  input remove_count, output ready);
endinterface

// ----- sv/pdos_out_if.sv -----
// ----------------------------------------------------------------------------
// pdos_out_if
// Result channel out of the disk store: overlap flags and stored count.
// ----------------------------------------------------------------------------
interface pdos_out_if;
  logic        valid;
  logic        ready;
  logic        overlap_free;
  logic        appended;
  logic        store_full;
  logic [11:0] stored_count;

  modport source (output valid, output overlap_free, output appended,
                  output store_full, output stored_count, input ready);
  modport sink   (input valid, input overlap_free, input appended,
                  input store_full, input stored_count, output ready);
endinterface

// ----- sv/pdos_image_test.sv -----
// ----------------------------------------------------------------------------
// pdos_image_test
// Three-stage pipeline: tests one stored centre and its eight periodic
// images against the trial centre, one centre per cycle.
// ----------------------------------------------------------------------------
module pdos_image_test (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic signed [pdos_pkg::COORD_W-1:0] cx_i,
  input  logic signed [pdos_pkg::COORD_W-1:0] cy_i,
  input  logic signed [pdos_pkg::COORD_W-1:0] tx_i,
  input  logic signed [pdos_pkg::COORD_W-1:0] ty_i,
  input  logic [pdos_pkg::D2_W-1:0]           d2_i,
  output pdos_pkg::pdos_hit_t                 hit_o
);
  import pdos_pkg::*;

  function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    return (v < 0) ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  logic signed [DIFF_W-1:0] dx0, dy0;
  logic [MAG_W-1:0] mag_d [6];
  logic [MAG_W-1:0] mag_q [6];
  logic [SQ_W-1:0]  sq_q  [6];
  logic             near;
  logic             v1_q, v2_q, v3_q, hit_q;

  // entries 0..2: x shifted by -1, 0, +1 box; 3..5: same for y
  always_comb begin
    dx0 = $signed({{2{cx_i[COORD_W-1]}}, cx_i}) - $signed({{2{tx_i[COORD_W-1]}}, tx_i});
    dy0 = $signed({{2{cy_i[COORD_W-1]}}, cy_i}) - $signed({{2{ty_i[COORD_W-1]}}, ty_i});
    mag_d[0] = mag(dx0 - BOX_ONE);
    mag_d[1] = mag(dx0);
    mag_d[2] = mag(dx0 + BOX_ONE);
    mag_d[3] = mag(dy0 - BOX_ONE);
    mag_d[4] = mag(dy0);
    mag_d[5] = mag(dy0 + BOX_ONE);
  end

  always_comb begin
    near = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 3; j < 6; j++) begin
        if (({1'b0, sq_q[i]} + {1'b0, sq_q[j]}) < (SQ_W + 1)'(d2_i)) begin
          near = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      mag_q[i] <= mag_d[i];
      sq_q[i]  <= SQ_W'(mag_q[i]) * SQ_W'(mag_q[i]);
    end
    hit_q <= near;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign hit_o.valid = v3_q;
  assign hit_o.hit   = hit_q;

endmodule

// ----- sv/periodic_disk_overlap_store.sv -----
// ----------------------------------------------------------------------------
// periodic_disk_overlap_store
// Stack of disk centres in a periodic unit square with overlap test,
// append, rollback and clear.
// ----------------------------------------------------------------------------
// One item at a time. In a test or append item the centre memory, which has
// one read port, delivers one stored centre per cycle into the nine-image test
// pipeline (read register, then magnitude, square and compare registers).
// Remove and clear items, and tests on an empty store, skip the scan. The
// centre memory needs no clearing after reset; only entries below the count
// are read. diameter_squared is at byte address 0 (64-bit data).
// ----------------------------------------------------------------------------
module periodic_disk_overlap_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pdos_in_if.sink                        in_i,
  pdos_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pdos_pkg::PADDR_W-1:0]   paddr,
  input  logic [pdos_pkg::DATA_W-1:0]    pwdata,
  output logic [pdos_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import pdos_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  state_e state_q, state_d;

  logic [D2_W-1:0] d2_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] issue_q, results_q;
  logic             any_hit_q;

  pdos_mode_e                mode_q;
  logic signed [COORD_W-1:0] tx_q, ty_q;
  logic [11:0]               rc_q;

  logic        out_valid_q, out_free_q, out_app_q, out_full_q;
  logic [11:0] out_cnt_q;

  logic [2*COORD_W-1:0] mem [MAX_POINTS];
  logic [2*COORD_W-1:0] rd_q;
  logic                 rd_vld_q;
  logic                 mem_re, mem_we;

  logic      in_acc, cfg_we, slot_free, done, free_pt;
  logic      res_free, res_app, res_full;
  pdos_hit_t hit;
  logic [CMP_W-1:0]       rc_ext, cnt_ext;
  logic [CNT_W+11:0]      cnt_wide;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[3] == REG_D2);
  assign prdata = (paddr[3] == REG_D2) ? DATA_W'(d2_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_q <= D2_RESET;
    end else if (cfg_we) begin
      d2_q <= pwdata[D2_W-1:0];
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign mem_re     = (state_q == ST_SCAN) && (issue_q != count_q);
  assign done       = (state_q == ST_FINISH) && slot_free;
  assign free_pt    = !any_hit_q;

  // result and new count of the item being finished
  always_comb begin
    rc_ext   = CMP_W'(rc_q);
    cnt_ext  = CMP_W'(count_q);
    count_d  = count_q;
    res_free = 1'b0;
    res_app  = 1'b0;
    res_full = 1'b0;
    mem_we   = 1'b0;
    unique case (mode_q)
      MODE_TEST: begin
        res_free = free_pt;
      end
      MODE_APPEND: begin
        res_free = free_pt;
        if (free_pt) begin
          if (count_q < MAX_CNT) begin
            res_app = 1'b1;
            mem_we  = done;
            count_d = count_q + 1'b1;
          end else begin
            res_full = 1'b1;
          end
        end
      end
      MODE_REMOVE: begin
        count_d = (rc_ext >= cnt_ext) ? '0 : CNT_W'(cnt_ext - rc_ext);
      end
      MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    cnt_wide = (CNT_W + 12)'(count_d);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (((in_i.mode == MODE_TEST) || (in_i.mode == MODE_APPEND)) &&
              (count_q != '0)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (results_q == count_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // centre memory: x in the upper half, y in the lower half
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[ADDR_W-1:0]] <= {tx_q, ty_q};
    end
    if (mem_re) begin
      rd_q <= mem[issue_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= pdos_mode_e'(in_i.mode);
      tx_q   <= in_i.trial_x;
      ty_q   <= in_i.trial_y;
      rc_q   <= in_i.remove_count;
    end
    if (done) begin
      out_free_q <= res_free;
      out_app_q  <= res_app;
      out_full_q <= res_full;
      out_cnt_q  <= cnt_wide[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      results_q   <= '0;
      any_hit_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= mem_re;
      if (in_acc) begin
        issue_q   <= '0;
        results_q <= '0;
        any_hit_q <= 1'b0;
      end else begin
        if (mem_re) begin
          issue_q <= issue_q + 1'b1;
        end
        if (hit.valid) begin
          results_q <= results_q + 1'b1;
          any_hit_q <= any_hit_q | hit.hit;
        end
      end
      if (done) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  pdos_image_test u_image_test (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_vld_q),
    .cx_i    (rd_q[2*COORD_W-1:COORD_W]),
    .cy_i    (rd_q[COORD_W-1:0]),
    .tx_i    (tx_q),
    .ty_i    (ty_q),
    .d2_i    (d2_q),
    .hit_o   (hit)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.overlap_free = out_free_q;
  assign out_o.appended     = out_app_q;
  assign out_o.store_full   = out_full_q;
  assign out_o.stored_count = out_cnt_q;

endmodule

// ----- sv/pdos_checker.sv -----
// ----------------------------------------------------------------------------
// pdos_checker
// Port-level assertions for the periodic disk overlap store, bound to it.
// ----------------------------------------------------------------------------
module pdos_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        overlap_free_i,
  input logic        appended_i,
  input logic        store_full_i,
  input logic [11:0] stored_count_i
);

  // stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({overlap_free_i, appended_i, store_full_i, stored_count_i}))
    else $error("result word changed while stalled");

  // an append only happens for a free point and never reports full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && appended_i |-> overlap_free_i && !store_full_i)
    else $error("append without free point or with full flag");

  // full is only flagged for a free point that was not stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && store_full_i |-> overlap_free_i && !appended_i)
    else $error("full flag on overlapping or stored point");

  // after an append the store holds at least one centre
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && appended_i |-> stored_count_i != 12'd0)
    else $error("append left store empty");

endmodule

bind periodic_disk_overlap_store pdos_checker u_pdos_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .overlap_free_i (out_o.overlap_free),
  .appended_i     (out_o.appended),
  .store_full_i   (out_o.store_full),
  .stored_count_i (out_o.stored_count)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the periodic disk overlap store. Items go in on the
// item channel, each result word is checked against a behavioral copy of the
// store kept here, and diameter_squared is written and read back over APB
// between phases. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import pdos_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam logic [PADDR_W-1:0] D2_ADDR = {REG_D2, 3'b000};
  localparam logic [D2_W-1:0] D2_MAX     = {D2_W{1'b1}};
  localparam int BOX                     = 65536;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic        overlap_free;
    logic        appended;
    logic        store_full;
    logic [11:0] stored_count;
  } disk_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  pdos_in_if  in_ch ();
  pdos_out_if out_ch ();

  periodic_disk_overlap_store dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // behavioral copy of the store
  coord_t              centre_x [MAX_POINTS];
  coord_t              centre_y [MAX_POINTS];
  int unsigned         centre_count;
  logic [D2_W-1:0]     diam_sq;

  disk_result_t awaited_results[$];

  bit          idling_on;
  int unsigned fail_count;
  int unsigned items_taken;
  int unsigned results_seen;
  int unsigned appends_seen;
  int unsigned refusals_seen;
  int unsigned reg_writes;
  int unsigned quiet_cycles;

  function automatic bit hits_any(coord_t tx, coord_t ty);
    longint dx;
    longint dy;
    for (int unsigned k = 0; k < centre_count; k++) begin
      for (int sx = -1; sx <= 1; sx++) begin
        for (int sy = -1; sy <= 1; sy++) begin
          dx = longint'(centre_x[k]) + sx * BOX - longint'(tx);
          dy = longint'(centre_y[k]) + sy * BOX - longint'(ty);
          if (dx * dx + dy * dy < longint'(diam_sq)) return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic disk_result_t step_disk_store(pdos_mode_e mode, coord_t tx, coord_t ty,
                                                   logic [11:0] rc);
    disk_result_t r;
    r = '0;
    unique case (mode)
      MODE_TEST, MODE_APPEND: begin
        r.overlap_free = !hits_any(tx, ty);
        if (mode == MODE_APPEND && r.overlap_free) begin
          if (centre_count < MAX_POINTS) begin
            centre_x[centre_count] = tx;
            centre_y[centre_count] = ty;
            centre_count++;
            r.appended = 1'b1;
          end else begin
            r.store_full = 1'b1;
          end
        end
      end
      MODE_REMOVE: begin
        centre_count = (int'(rc) >= centre_count) ? 0 : centre_count - rc;
      end
      default: begin
        centre_count = 0;
      end
    endcase
    r.stored_count = centre_count[11:0];
    return r;
  endfunction

  task automatic report_field(string name, longint unsigned exp_v, longint unsigned act_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
  endtask

  // accepted items feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      awaited_results.push_back(step_disk_store(pdos_mode_e'(in_ch.mode), in_ch.trial_x,
                                                in_ch.trial_y, in_ch.remove_count));
      items_taken++;
    end
  end

  // result checker
  always @(posedge clk) begin
    disk_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.appended) appends_seen++;
      if (out_ch.store_full) refusals_seen++;
      if (awaited_results.size() == 0) begin
        report_field("unexpected result word, stored_count", 0, out_ch.stored_count);
      end else begin
        e = awaited_results.pop_front();
        if (out_ch.overlap_free !== e.overlap_free)
          report_field("overlap_free", e.overlap_free, out_ch.overlap_free);
        if (out_ch.appended !== e.appended)
          report_field("appended", e.appended, out_ch.appended);
        if (out_ch.store_full !== e.store_full)
          report_field("store_full", e.store_full, out_ch.store_full);
        if (out_ch.stored_count !== e.stored_count)
          report_field("stored_count", e.stored_count, out_ch.stored_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure in bursts
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(1, 4) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_item(pdos_mode_e mode, coord_t x, coord_t y, logic [11:0] rc);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.mode         = mode;
    in_ch.trial_x      = x;
    in_ch.trial_y      = y;
    in_ch.remove_count = rc;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    in_ch.valid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  task automatic apb_transfer(logic write, logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = D2_ADDR;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // only called with the store idle; the value is read back as well
  task automatic set_diameter(logic [D2_W-1:0] value);
    logic [DATA_W-1:0] rd;
    wait_until_drained();
    apb_transfer(1'b1, DATA_W'(value), rd);
    diam_sq = value;
    reg_writes++;
    apb_transfer(1'b0, '0, rd);
    if (rd[D2_W-1:0] !== value) report_field("diameter_squared readback", value, rd[D2_W-1:0]);
  endtask

  function automatic coord_t box_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return COORD_W'($urandom_range(0, 3000));
    if (r < 4) return COORD_W'($urandom_range(BOX - 3000, BOX - 1));
    return COORD_W'($urandom_range(0, BOX - 1));
  endfunction

  function automatic coord_t any_coord();
    return COORD_W'($urandom);
  endfunction

  // extremes, empty store, images, rollback past zero
  task automatic test_directed();
    send_item(MODE_TEST, -18'sd131072, -18'sd131072, 12'd0);
    send_item(MODE_TEST, 18'sd131071, 18'sd131071, 12'hFFF);
    send_item(MODE_REMOVE, 18'sd0, 18'sd0, 12'hFFF);
    send_item(MODE_CLEAR, 18'sd131071, -18'sd131072, 12'd0);
    send_item(MODE_APPEND, 18'sd0, 18'sd0, 12'd0);
    // diameter is about 6553.6 in Q2.16 at the reset value
    send_item(MODE_TEST, 18'sd6553, 18'sd0, 12'd0);
    send_item(MODE_TEST, 18'sd6554, 18'sd0, 12'd0);
    send_item(MODE_TEST, 18'sd0, -18'sd6553, 12'd0);
    send_item(MODE_TEST, 18'sd58983, 18'sd0, 12'd0);
    send_item(MODE_TEST, 18'sd62000, 18'sd62000, 12'd0);
    send_item(MODE_TEST, 18'sd60000, 18'sd60000, 12'd0);
    send_item(MODE_TEST, -18'sd3000, 18'sd4000, 12'd0);
    send_item(MODE_TEST, -18'sd131072, 18'sd131071, 12'd0);
    send_item(MODE_APPEND, 18'sd6553, 18'sd0, 12'd0);
    send_item(MODE_APPEND, 18'sd32768, 18'sd32768, 12'd0);
    send_item(MODE_APPEND, 18'sd65535, 18'sd65535, 12'd0);
    send_item(MODE_REMOVE, 18'sd0, 18'sd0, 12'd1);
    send_item(MODE_REMOVE, 18'sd0, 18'sd0, 12'd0);
    send_item(MODE_REMOVE, 18'sd0, 18'sd0, 12'd5);
    send_item(MODE_APPEND, 18'sd100, 18'sd100, 12'd0);
    send_item(MODE_CLEAR, 18'sd0, 18'sd0, 12'd0);
    send_item(MODE_APPEND, 18'sd131071, -18'sd131072, 12'd0);
    send_item(MODE_TEST, 18'sd131071, -18'sd131072, 12'd0);
    send_item(MODE_CLEAR, 18'sd0, 18'sd0, 12'd0);
    wait_until_drained();
  endtask

  // mostly chain growth with tests and short rollbacks, some noise
  task automatic run_chain_phase(logic [D2_W-1:0] d2, int n);
    int unsigned r;
    set_diameter(d2);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55)      send_item(MODE_APPEND, box_coord(), box_coord(), 12'($urandom));
      else if (r < 75) send_item(MODE_TEST, box_coord(), box_coord(), 12'($urandom));
      else if (r < 85) send_item(MODE_REMOVE, any_coord(), any_coord(),
                                 12'($urandom_range(0, 6)));
      else if (r < 88) send_item(MODE_CLEAR, any_coord(), any_coord(), 12'($urandom));
      else if (r < 95) send_item(pdos_mode_e'($urandom_range(0, 1)), any_coord(), any_coord(),
                                 12'($urandom));
      else             send_item(MODE_REMOVE, any_coord(), any_coord(), 12'($urandom));
    end
    wait_until_drained();
  endtask

  task automatic test_random_chains();
    run_chain_phase(D2_RESET, 50);
    run_chain_phase(D2_W'(10737418), 50);
    run_chain_phase(D2_W'($urandom_range(0, 1 << 28)), 50);
    run_chain_phase('0, 40);
    run_chain_phase(D2_MAX, 40);
    idling_on = 1'b0;
    run_chain_phase(D2_W'(26843546), 40);
  endtask

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_TEST;
    in_ch.trial_x      = '0;
    in_ch.trial_y      = '0;
    in_ch.remove_count = '0;
    idling_on          = 1'b1;
    fail_count         = 0;
    items_taken        = 0;
    results_seen       = 0;
    appends_seen       = 0;
    refusals_seen      = 0;
    reg_writes         = 0;
    quiet_cycles       = 0;
    centre_count       = 0;
    diam_sq            = D2_RESET;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_chains();

    wait_until_drained();
    repeat (20) @(negedge clk);
    $display("Run covered %0d items and %0d result words over %0d diameter settings,",
             items_taken, results_seen, reg_writes);
    $display("with %0d appends and %0d refusals on a full store.", appends_seen, refusals_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pdos_pkg.sv
sv/pdos_in_if.sv
sv/pdos_out_if.sv
sv/pdos_image_test.sv
sv/periodic_disk_overlap_store.sv
sv/pdos_checker.sv
bench/tb.sv
